// ===== design/piea_pkg.sv =====
`default_nettype none

package piea_pkg;

  // Store geometry
  localparam int NUM_CELLS = 4096;
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int CNT_W     = CELL_W + 1;
  localparam int POS_W     = 12;

  // Field widths
  localparam int E_W     = 48;
  localparam int GAIN_W  = 32;
  localparam int IMP_W   = 16;
  localparam int EG_W    = IMP_W + GAIN_W;
  localparam int R_W     = 17;

  // Reciprocal square root table covers every distance a position can give
  localparam int TBL_DEPTH = 2 ** POS_W;
  localparam int TA_W      = POS_W;

  localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd2;

  // Configuration reset values
  localparam logic [CNT_W-1:0]  CELLS_RST = 13'd4096;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 32'd16000;
  localparam logic [E_W-1:0]    MIN_RST   = 48'd1049;

  // Request types
  localparam logic REQ_IMPACT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Control from the sequencer to the cell store
  typedef struct packed {
    logic              rd_en;
    logic              upd;
    logic [CELL_W-1:0] addr;
  } cell_ctrl_t;

  // Status from the cell store
  typedef struct packed {
    logic clear_done;
    logic busy;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== design/particle_impact_energy_accumulator.sv =====
`default_nettype none

// Particle impact energy accumulator. After reset the block clears its
// 4096-entry energy store and, in parallel, builds its reciprocal square root
// table; in_ready stays low until both are done, while configuration writes
// are taken at any time. For an impact item, one cell per cycle goes through
// a read-modify-write pipeline on the cell memory, and the pipeline drains
// before the next item is taken. Impacts give no result. A read item returns
// the cell's Q24.24 energy; it can be accepted while an earlier result still
// waits on the output register. Registers: index 0 cells_in_use, 1 gain
// (Q16.16), 2 energy threshold (Q24.24); other indexes are ignored. Write
// them only while the block is idle.
module particle_impact_energy_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              req_type,
  input  wire logic [piea_pkg::IMP_W-1:0]        impact_energy,
  input  wire logic [piea_pkg::POS_W-1:0]        position,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [piea_pkg::E_W-1:0]          cell_energy_out,
  output logic      [piea_pkg::POS_W-1:0]        read_position,
  // Configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [piea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [piea_pkg::E_W-1:0]          cfg_data
);

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SWEEP   = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_RD_WAIT = 3'd4;

  logic [2:0] state, state_next;

  // Configuration
  logic [piea_pkg::CNT_W-1:0]  cells_in_use;
  logic [piea_pkg::GAIN_W-1:0] gain;
  logic [piea_pkg::E_W-1:0]    threshold;

  // Item context
  logic [piea_pkg::EG_W-1:0]   eg;
  logic [piea_pkg::POS_W-1:0]  imp_pos;
  logic [piea_pkg::POS_W-1:0]  rd_pos;
  logic [piea_pkg::CNT_W-1:0]  count;
  logic [piea_pkg::CNT_W-1:0]  cnt;

  logic                        in_acc;
  logic                        out_load;
  logic [piea_pkg::CELL_W-1:0] cell_idx;
  logic [piea_pkg::POS_W-1:0]  offset;
  logic [piea_pkg::CNT_W-1:0]  count_lim;

  piea_pkg::cell_ctrl_t        ctrl;
  piea_pkg::cell_stat_t        stat;
  logic [piea_pkg::R_W-1:0]    r_val;
  logic                        tbl_done;
  logic [piea_pkg::E_W-1:0]    rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_RD_WAIT) && (!out_valid || out_ready);

  assign cell_idx  = cnt[piea_pkg::CELL_W-1:0];
  assign offset    = (imp_pos > piea_pkg::POS_W'(cell_idx))
                   ? imp_pos - piea_pkg::POS_W'(cell_idx)
                   : piea_pkg::POS_W'(cell_idx) - imp_pos;
  assign count_lim = (cells_in_use > piea_pkg::CNT_W'(piea_pkg::NUM_CELLS))
                   ? piea_pkg::CNT_W'(piea_pkg::NUM_CELLS) : cells_in_use;

  // Cell store access: read items and sweep issues share the read port
  always_comb begin
    ctrl.rd_en = 1'b0;
    ctrl.upd   = 1'b0;
    ctrl.addr  = cell_idx;
    if (state == ST_SWEEP) begin
      ctrl.rd_en = 1'b1;
      ctrl.upd   = 1'b1;
    end else if (in_acc && req_type == piea_pkg::REQ_READ) begin
      ctrl.rd_en = 1'b1;
      ctrl.addr  = piea_pkg::CELL_W'(position);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (stat.clear_done && tbl_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type == piea_pkg::REQ_READ) begin
            state_next = ST_RD_WAIT;
          end else if (count_lim != '0) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (cnt == count - 1'b1) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_IDLE;
      end
      ST_RD_WAIT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      out_valid    <= 1'b0;
      cnt          <= '0;
      cells_in_use <= piea_pkg::CELLS_RST;
      gain         <= piea_pkg::GAIN_RST;
      threshold    <= piea_pkg::MIN_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        cnt <= '0;
      end else if (state == ST_SWEEP) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          piea_pkg::CFG_CELLS: cells_in_use <= cfg_data[piea_pkg::CNT_W-1:0];
          piea_pkg::CFG_GAIN:  gain         <= cfg_data[piea_pkg::GAIN_W-1:0];
          piea_pkg::CFG_MIN:   threshold    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Item context and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      eg      <= piea_pkg::EG_W'(impact_energy) * piea_pkg::EG_W'(gain);
      imp_pos <= position;
      rd_pos  <= position;
      count   <= count_lim;
    end
    if (out_load) begin
      cell_energy_out <= (piea_pkg::CNT_W'(rd_pos) < piea_pkg::CNT_W'(piea_pkg::NUM_CELLS))
                       ? rd_data : '0;
      read_position   <= rd_pos;
    end
  end

  piea_rsqrt_table u_rsqrt (
    .clk   (clk),
    .rst   (rst),
    .addr  (offset),
    .r_out (r_val),
    .done  (tbl_done)
  );

  piea_cell_store u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .r_in       (r_val),
    .eg         (eg),
    .threshold  (threshold),
    .rd_data    (rd_data),
    .stat       (stat)
  );

endmodule

`default_nettype wire

// ===== design/piea_rsqrt_table.sv =====
`default_nettype none

// Table of floor(2^16 / sqrt(d + 1)) indexed by distance d.
// Filled after reset by walking n = 1 .. TBL_DEPTH and keeping r*r*n <= 2^32,
// with r*r, r*n and r*r*n tracked incrementally (no multiplier).
module piea_rsqrt_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [piea_pkg::TA_W-1:0]     addr,
  output logic      [piea_pkg::R_W-1:0]      r_out,
  output logic                               done
);

  localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

  logic [piea_pkg::R_W-1:0] tbl [piea_pkg::TBL_DEPTH];

  // Walker state
  logic [12:0]              n;
  logic [piea_pkg::R_W-1:0] r;
  logic [32:0]              sq;
  logic [33:0]              p;
  logic [25:0]              q;
  logic [12:0]              n_m1;
  logic                     too_big;

  assign n_m1    = n - 13'd1;
  assign too_big = (p > ONE_Q32);

  // Walk: shrink r until r*r*n fits, then record and move to the next n
  always_ff @(posedge clk) begin
    if (rst) begin
      n    <= 13'd1;
      r    <= 17'h10000;
      sq   <= 33'h1_0000_0000;
      p    <= ONE_Q32;
      q    <= 26'h10000;
      done <= 1'b0;
    end else if (!done) begin
      if (too_big) begin
        r  <= r - 17'd1;
        sq <= sq - (33'(r) << 1) + 33'd1;
        p  <= p - (34'(q) << 1) + 34'(n);
        q  <= q - 26'(n);
      end else if (n == 13'(piea_pkg::TBL_DEPTH)) begin
        done <= 1'b1;
      end else begin
        n <= n + 13'd1;
        p <= p + 34'(sq);
        q <= q + 26'(r);
      end
    end
  end

  // Table memory: one write port for the fill, one registered read port
  always_ff @(posedge clk) begin
    if (!done && !too_big) begin
      tbl[n_m1[piea_pkg::TA_W-1:0]] <= r;
    end
    r_out <= tbl[addr];
  end

endmodule

`default_nettype wire

// ===== design/piea_cell_store.sv =====
`default_nettype none

// Cell energy memory with its clearing pass and the update pipeline:
// S1 partial products, S2 combine and saturate, S3 accumulate and write back.
module piea_cell_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire piea_pkg::cell_ctrl_t          ctrl,
  input  wire logic [piea_pkg::R_W-1:0]      r_in,
  input  wire logic [piea_pkg::EG_W-1:0]     eg,
  input  wire logic [piea_pkg::E_W-1:0]      threshold,
  output logic      [piea_pkg::E_W-1:0]      rd_data,
  output piea_pkg::cell_stat_t               stat
);

  localparam int HALF_W = piea_pkg::EG_W / 2;
  localparam int PP_W   = HALF_W + piea_pkg::R_W;
  localparam int PROD_W = piea_pkg::EG_W + piea_pkg::R_W;

  logic [piea_pkg::E_W-1:0] mem [piea_pkg::NUM_CELLS];

  logic [piea_pkg::CNT_W-1:0] clr_cnt;
  logic                       clear_done;

  logic                         s1_valid, s2_valid, s3_valid;
  logic [piea_pkg::CELL_W-1:0]  s1_addr, s2_addr, s3_addr;
  logic [PP_W-1:0]              pl, ph;
  logic [piea_pkg::E_W-1:0]     old2, old3, inc3;

  logic [PROD_W-1:0]            prod;
  logic [PROD_W-9:0]            inc_full;
  logic [piea_pkg::E_W-1:0]     inc_sat;
  logic [piea_pkg::E_W:0]       sum;
  logic [piea_pkg::E_W-1:0]     sum_sat;
  logic                         wr_upd;

  assign clear_done = (clr_cnt == piea_pkg::CNT_W'(piea_pkg::NUM_CELLS));

  // S2 combine: increment is the product in Q24.24, saturated to 48 bits
  assign prod     = (PROD_W'(ph) << HALF_W) + PROD_W'(pl);
  assign inc_full = prod[PROD_W-1:8];
  assign inc_sat  = (|inc_full[PROD_W-9:piea_pkg::E_W]) ? piea_pkg::E_MAX
                                                        : inc_full[piea_pkg::E_W-1:0];

  // S3 accumulate with saturation and threshold
  assign sum     = {1'b0, old3} + {1'b0, inc3};
  assign sum_sat = sum[piea_pkg::E_W] ? piea_pkg::E_MAX : sum[piea_pkg::E_W-1:0];
  assign wr_upd  = s3_valid && (sum_sat >= threshold);

  // Control: clearing pass and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (!clear_done) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      s1_valid <= ctrl.upd;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_addr <= ctrl.addr;
    s2_addr <= s1_addr;
    s3_addr <= s2_addr;
    pl      <= PP_W'(eg[HALF_W-1:0]) * PP_W'(r_in);
    ph      <= PP_W'(eg[piea_pkg::EG_W-1:HALF_W]) * PP_W'(r_in);
    old2    <= rd_data;
    old3    <= old2;
    inc3    <= inc_sat;
  end

  // Memory: clear or write back, registered read
  always_ff @(posedge clk) begin
    if (!clear_done) begin
      mem[clr_cnt[piea_pkg::CELL_W-1:0]] <= '0;
    end else if (wr_upd) begin
      mem[s3_addr] <= sum_sat;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.addr];
    end
  end

  assign stat.clear_done = clear_done;
  assign stat.busy       = s1_valid | s2_valid | s3_valid;

endmodule

`default_nettype wire

// ===== tb/energy_store_checker.sv =====
module energy_store_checker
  import piea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 req_type,
  input  logic [IMP_W-1:0]     impact_energy,
  input  logic [POS_W-1:0]     position,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [E_W-1:0]       cell_energy_out,
  input  logic [POS_W-1:0]     read_position,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [E_W-1:0]       cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [E_W-1:0]   energy;
    logic [POS_W-1:0] pos;
  } read_result_t;

  // Predicted store contents and register copies
  logic [E_W-1:0]    cell_energy_model [NUM_CELLS];
  logic [R_W-1:0]    inv_sqrt_q16 [NUM_CELLS];
  logic [CNT_W-1:0]  cells_reg;
  logic [GAIN_W-1:0] gain_reg;
  logic [E_W-1:0]    min_reg;
  read_result_t      expected_reads [$];
  int                fail_count = 0;

  // floor(2^16 / sqrt(d + 1)) for every distance d, as isqrt(2^32 / (d + 1))
  initial begin
    logic [63:0]    quot;
    logic [63:0]    trial;
    logic [R_W-1:0] root;
    for (int d = 0; d < NUM_CELLS; d++) begin
      quot = (64'd1 << 32) / (d + 1);
      root = '0;
      for (int b = 16; b >= 0; b--) begin
        trial = 64'(root) | (64'd1 << b);
        if (trial * trial <= quot)
          root = trial[R_W-1:0];
      end
      inv_sqrt_q16[d] = root;
    end
  end

  // Spread one impact over the swept cells, saturating, gated by the threshold
  function automatic void deposit_impact(input logic [IMP_W-1:0] e, input logic [POS_W-1:0] p);
    logic [EG_W-1:0] eg;
    logic [63:0]     prod;
    logic [E_W-1:0]  inc;
    logic [E_W:0]    sum;
    logic [E_W-1:0]  next_val;
    int              sweep;
    int              offset;
    eg = EG_W'(e) * EG_W'(gain_reg);
    sweep = (int'(cells_reg) > NUM_CELLS) ? NUM_CELLS : int'(cells_reg);
    for (int i = 0; i < sweep; i++) begin
      offset = (int'(p) > i) ? int'(p) - i : i - int'(p);
      prod = 64'(eg) * 64'(inv_sqrt_q16[offset]);
      inc = (prod[63:56] != '0) ? E_MAX : prod[55:8];
      sum = {1'b0, cell_energy_model[i]} + {1'b0, inc};
      next_val = sum[E_W] ? E_MAX : sum[E_W-1:0];
      if (next_val >= min_reg)
        cell_energy_model[i] = next_val;
    end
  endfunction

  always @(posedge clk) begin
    read_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CELLS; i++)
        cell_energy_model[i] = '0;
      cells_reg = CELLS_RST;
      gain_reg  = GAIN_RST;
      min_reg   = MIN_RST;
      expected_reads.delete();
    end else begin
      // Results first: an item accepted at this edge cannot be answered yet
      if (out_valid && out_ready) begin
        if (expected_reads.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual pos %0d energy %h",
                   $time, read_position, cell_energy_out);
        end else begin
          want = expected_reads.pop_front();
          if (read_position !== want.pos) begin
            fail_count++;
            $display("%0t: read_position mismatch, expected %0d actual %0d",
                     $time, want.pos, read_position);
          end
          if (cell_energy_out !== want.energy) begin
            fail_count++;
            $display("%0t: cell_energy_out mismatch at pos %0d, expected %h actual %h",
                     $time, want.pos, want.energy, cell_energy_out);
          end
        end
      end

      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CELLS: cells_reg = cfg_data[CNT_W-1:0];
          CFG_GAIN:  gain_reg  = cfg_data[GAIN_W-1:0];
          CFG_MIN:   min_reg   = cfg_data;
          default: ;
        endcase
      end

      // Requests
      if (in_valid && in_ready) begin
        if (req_type == REQ_READ) begin
          want.pos = position;
          want.energy = (int'(position) < NUM_CELLS) ? cell_energy_model[position] : '0;
          expected_reads.push_back(want);
        end else begin
          deposit_impact(impact_energy, position);
        end
      end
    end
    pending <= expected_reads.size();
    errors  <= fail_count;
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import piea_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = REQ_IMPACT;
  logic [IMP_W-1:0]     impact_energy = '0;
  logic [POS_W-1:0]     position = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [E_W-1:0]       cell_energy_out;
  logic [POS_W-1:0]     read_position;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CELLS;
  logic [E_W-1:0]       cfg_data = '0;
  int                   errors;
  int                   pending;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cur_cells     = 4096;

  always #5 clk = ~clk;

  particle_impact_energy_accumulator DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .impact_energy   (impact_energy),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_energy_out (cell_energy_out),
    .read_position   (read_position),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  energy_store_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .impact_energy   (impact_energy),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_energy_out (cell_energy_out),
    .read_position   (read_position),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .pending         (pending)
  );

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one item; valid stays up after acceptance unless the next one idles
  task automatic send_request(input logic kind, input logic [IMP_W-1:0] e,
                              input logic [POS_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    impact_energy <= e;
    position      <= p;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [E_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input int cells, input logic [GAIN_W-1:0] g,
                               input logic [E_W-1:0] thr);
    write_reg(CFG_CELLS, E_W'(cells));
    write_reg(CFG_GAIN, E_W'(g));
    write_reg(CFG_MIN, thr);
    cfg_valid <= 1'b0;
    cur_cells = cells;
  endtask

  // Wait for all reads to return, then for a full sweep to drain;
  // the first edge lets the checker count the last accepted item
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (((cur_cells > NUM_CELLS) ? NUM_CELLS : cur_cells) + 8) @(posedge clk);
  endtask

  // Random mix of impacts and reads under one setting and idling profile
  task automatic random_burst(input int idle, input int stall, input int cells,
                              input logic [GAIN_W-1:0] g, input int n);
    logic [63:0] thr;
    int          span;
    drain();
    thr = {$urandom(), $urandom()} >> $urandom_range(16, 63);
    load_settings(cells, g, thr[E_W-1:0]);
    send_idle_pct = idle;
    stall_pct     = stall;
    span = (cells > NUM_CELLS) ? NUM_CELLS : cells;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55)
        send_request(REQ_READ, IMP_W'($urandom()),
                     ($urandom_range(3) != 0) ? POS_W'($urandom_range(span - 1))
                                              : POS_W'($urandom_range(4095)));
      else
        send_request(REQ_IMPACT, IMP_W'($urandom_range(65535)),
                     $urandom_range(1) ? POS_W'($urandom_range(span - 1))
                                       : POS_W'($urandom_range(4095)));
    end
  endtask

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty store, full sweep
    send_request(REQ_READ, '0, 12'd0);
    send_request(REQ_READ, '1, 12'd4095);
    send_request(REQ_IMPACT, 16'd1, 12'd2048);
    send_request(REQ_READ, '0, 12'd2048);
    send_request(REQ_READ, '0, 12'd0);

    // High threshold: small deposits are dropped
    drain();
    load_settings(100, 32'd1, 48'h0000_0010_0000);
    send_request(REQ_IMPACT, 16'h00FF, 12'd50);
    send_request(REQ_READ, '0, 12'd50);
    send_request(REQ_READ, '0, 12'd49);

    // Sweep length above the store size, zero threshold, zero energy
    drain();
    load_settings(8191, 32'd1, '0);
    send_request(REQ_IMPACT, 16'hFFFF, 12'd4095);
    send_request(REQ_IMPACT, 16'h0000, 12'd1000);
    send_request(REQ_READ, '0, 12'd4095);
    send_request(REQ_READ, '0, 12'd0);

    // Maximum gain saturates the first two cells
    drain();
    load_settings(2, 32'hFFFF_FFFF, '0);
    send_request(REQ_IMPACT, 16'hFFFF, 12'd0);
    send_request(REQ_READ, '0, 12'd0);
    send_request(REQ_READ, '0, 12'd1);

    // Zero sweep, maximum threshold, write to an unused index
    drain();
    write_reg(CFG_SPARE, E_W'({$urandom(), $urandom()}));
    load_settings(0, 32'd16000, E_MAX);
    send_request(REQ_IMPACT, 16'h8000, 12'd7);
    send_request(REQ_READ, '0, 12'd7);
    send_request(REQ_READ, '0, 12'd2);

    // Random part under the four idling profiles
    random_burst(0, 0, $urandom_range(1, 64), $urandom_range(0, 1 << 18), 30);
    random_burst(80, 0, $urandom_range(1, 300), $urandom_range(0, 1 << 18), 30);
    random_burst(0, 80, 4096, $urandom_range(0, 1 << 16), 30);
    random_burst(37, 37, $urandom_range(1, 8191), $urandom(), 30);

    drain();
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
